FILE: src/ccc_pkg.sv
// Shared types and constants for the color contrast checker.
// Holds the sRGB-to-linear table, built at elaboration by an exact rational search.
// No dependencies.
`timescale 1ns / 1ps

package ccc_pkg;

  localparam int unsigned LUMA_BITS = 16;
  localparam int unsigned PIPE_DEPTH = 5;
  localparam int unsigned BIG_W = 320;
  localparam int unsigned PROD_W = LUMA_BITS + 16;
  localparam int unsigned SUM_W = PROD_W + 2;
  localparam int unsigned CMP_W = LUMA_BITS + 9;

  localparam logic [7:0] RATIO_RESET = 8'd45;

  localparam logic [15:0] W_RED = 16'd13933;
  localparam logic [15:0] W_GREEN = 16'd46871;
  localparam logic [15:0] W_BLUE = 16'd4732;

  localparam longint unsigned LIN_SCALE = (64'd1 << LUMA_BITS) - 64'd1;

  typedef logic [LUMA_BITS-1:0] lin_t;
  typedef lin_t lin_tab_t [256];
  typedef logic [BIG_W-1:0] big_t;

  // round(0.05 * 2^LUMA_BITS)
  localparam lin_t LUMA_OFF = lin_t'(((64'd1 << LUMA_BITS) + 64'd10) / 64'd20);

  function automatic big_t big_pow(big_t base, int unsigned n);
    big_t acc;
    acc = big_t'(1);
    for (int unsigned i = 0; i < n; i++) begin
      acc = acc * base;
    end
    return acc;
  endfunction

  // For c > 10: largest k with (2k-1)^5 * 10761^12 <= (2*scale)^5 * (40c+561)^12,
  // i.e. round-half-up of scale * ((c/255 + 0.055)/1.055)^2.4.
  function automatic lin_t lin_entry(int unsigned c);
    big_t den;
    big_t rhs;
    big_t lhs;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned best;
    longint unsigned num;
    if (c <= 10) begin
      num = 64'd20 * longint'(c) * LIN_SCALE + 64'd32946;
      return lin_t'(num / 64'd65892);
    end
    den = big_pow(big_t'(10761), 12);
    rhs = big_pow(big_t'(2 * LIN_SCALE), 5) * big_pow(big_t'(40 * c + 561), 12);
    lo = 1;
    hi = LIN_SCALE;
    best = 0;
    while (lo <= hi) begin
      mid = lo + ((hi - lo) >> 1);
      lhs = den * big_pow(big_t'(2 * mid - 1), 5);
      if (lhs <= rhs) begin
        best = mid;
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    return lin_t'(best);
  endfunction

  function automatic lin_tab_t build_lin_tab();
    lin_tab_t tab;
    for (int unsigned c = 0; c < 256; c++) begin
      tab[c] = lin_entry(c);
    end
    return tab;
  endfunction

  localparam lin_tab_t LIN_TAB = build_lin_tab();

  // Internal luminance to Q0.16: shift left or right by the width difference.
  function automatic logic [15:0] to_q16(lin_t v);
    logic [LUMA_BITS+15:0] wide;
    wide = {v, 16'b0} >> LUMA_BITS;
    return wide[15:0];
  endfunction

endpackage

FILE: src/ccc_luma_lane.sv
// One luminance lane: table lookup, weighted products, sum and scale.
// Three register stages. Uses ccc_pkg.
`timescale 1ns / 1ps

module ccc_luma_lane (
  input  logic              clk,
  input  logic              en,
  input  logic [7:0]        red,
  input  logic [7:0]        green,
  input  logic [7:0]        blue,
  output ccc_pkg::lin_t     luma
);

  ccc_pkg::lin_t lin_r_r;
  ccc_pkg::lin_t lin_g_r;
  ccc_pkg::lin_t lin_b_r;
  logic [ccc_pkg::PROD_W-1:0] prod_r_r;
  logic [ccc_pkg::PROD_W-1:0] prod_g_r;
  logic [ccc_pkg::PROD_W-1:0] prod_b_r;
  logic [ccc_pkg::SUM_W-1:0]  sum;
  ccc_pkg::lin_t luma_r;

  assign sum = ccc_pkg::SUM_W'(prod_r_r) + ccc_pkg::SUM_W'(prod_g_r)
             + ccc_pkg::SUM_W'(prod_b_r);

  always_ff @(posedge clk) begin
    if (en) begin
      lin_r_r  <= ccc_pkg::LIN_TAB[red];
      lin_g_r  <= ccc_pkg::LIN_TAB[green];
      lin_b_r  <= ccc_pkg::LIN_TAB[blue];
      prod_r_r <= ccc_pkg::PROD_W'(lin_r_r) * ccc_pkg::PROD_W'(ccc_pkg::W_RED);
      prod_g_r <= ccc_pkg::PROD_W'(lin_g_r) * ccc_pkg::PROD_W'(ccc_pkg::W_GREEN);
      prod_b_r <= ccc_pkg::PROD_W'(lin_b_r) * ccc_pkg::PROD_W'(ccc_pkg::W_BLUE);
      // weights sum to 2^16, so the shifted sum always fits the lane width
      luma_r   <= ccc_pkg::lin_t'(sum >> 16);
    end
  end

  assign luma = luma_r;

endmodule

FILE: src/ccc_merge.sv
// Merge stage: orders the two lane luminances and tests the contrast ratio.
// Two register stages, the second is the output register. Uses ccc_pkg.
`timescale 1ns / 1ps

module ccc_merge (
  input  logic              clk,
  input  logic              en,
  input  ccc_pkg::lin_t     bg_luma,
  input  ccc_pkg::lin_t     fg_luma,
  input  logic [7:0]        ratio,
  output logic              passes,
  output logic [15:0]       bg_q16,
  output logic [15:0]       fg_q16
);

  logic [ccc_pkg::LUMA_BITS:0] hi_sum_r;
  logic [ccc_pkg::LUMA_BITS:0] lo_sum_r;
  ccc_pkg::lin_t bg_d_r;
  ccc_pkg::lin_t fg_d_r;
  ccc_pkg::lin_t hi_l;
  ccc_pkg::lin_t lo_l;
  logic [ccc_pkg::CMP_W-1:0] lhs;
  logic [ccc_pkg::CMP_W-1:0] rhs;
  logic passes_r;
  logic [15:0] bg_q16_r;
  logic [15:0] fg_q16_r;

  assign hi_l = (bg_luma > fg_luma) ? bg_luma : fg_luma;
  assign lo_l = (bg_luma > fg_luma) ? fg_luma : bg_luma;

  assign lhs = ccc_pkg::CMP_W'(hi_sum_r) * ccc_pkg::CMP_W'(10);
  assign rhs = ccc_pkg::CMP_W'(ratio) * ccc_pkg::CMP_W'(lo_sum_r);

  always_ff @(posedge clk) begin
    if (en) begin
      hi_sum_r <= {1'b0, hi_l} + {1'b0, ccc_pkg::LUMA_OFF};
      lo_sum_r <= {1'b0, lo_l} + {1'b0, ccc_pkg::LUMA_OFF};
      bg_d_r   <= bg_luma;
      fg_d_r   <= fg_luma;
      passes_r <= (lhs >= rhs);
      bg_q16_r <= ccc_pkg::to_q16(bg_d_r);
      fg_q16_r <= ccc_pkg::to_q16(fg_d_r);
    end
  end

  assign passes = passes_r;
  assign bg_q16 = bg_q16_r;
  assign fg_q16 = fg_q16_r;

endmodule

FILE: src/color_contrast_checker_core.sv
// Top level of the color contrast checker.
// Instantiates two ccc_luma_lane lanes and ccc_merge; uses ccc_pkg.
`timescale 1ns / 1ps

// Usage:
//   Input stream: one item is a background and a foreground sRGB color,
//   8 bits per channel. Output stream: one item per input, with the pass
//   flag and both relative luminances in Q0.16.
//   Config: cfg_wr_en writes cfg_wr_data as the minimum ratio in tenths
//   (45 = 4.5:1). Write it only while no items are in flight.
//   Pipeline: 3 lane stages (table lookup, weighted multiply, sum) and
//   2 merge stages (order and offset, ratio compare into the output
//   register) lie between input accept and output valid.
//   Throughput: one item per cycle unless stalled; the two color lanes run in
//   parallel and every stage is a single register, so a new item enters each cycle.
//   Stall: all stages advance together whenever the output register is empty
//   or being taken; when the receiver holds tready low with a valid item
//   waiting, in_tready drops and everything holds, empty slots included.
//   Reset: rst_n low clears all valid flags and loads the ratio 4.5:1.
//   The linear table is a constant ROM, no clearing pass is needed.

module color_contrast_checker_core (
  input  logic        clk,
  input  logic        rst_n,
  // fields from bit 0: bg_red, bg_green, bg_blue, fg_red, fg_green, fg_blue
  input  logic [47:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // fields from bit 0: passes, bg_luminance, fg_luminance, zero pad
  output logic [39:0] out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);

  logic [ccc_pkg::PIPE_DEPTH-1:0] vld_r;
  logic [7:0] ratio_r;
  logic en;
  ccc_pkg::lin_t bg_luma;
  ccc_pkg::lin_t fg_luma;
  logic passes;
  logic [15:0] bg_q16;
  logic [15:0] fg_q16;

  assign en = !vld_r[ccc_pkg::PIPE_DEPTH-1] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[ccc_pkg::PIPE_DEPTH-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r <= ccc_pkg::RATIO_RESET;
    end else if (cfg_wr_en) begin
      ratio_r <= cfg_wr_data;
    end
  end

  ccc_luma_lane u_bg_lane (
    .clk   (clk),
    .en    (en),
    .red   (in_tdata[7:0]),
    .green (in_tdata[15:8]),
    .blue  (in_tdata[23:16]),
    .luma  (bg_luma)
  );

  ccc_luma_lane u_fg_lane (
    .clk   (clk),
    .en    (en),
    .red   (in_tdata[31:24]),
    .green (in_tdata[39:32]),
    .blue  (in_tdata[47:40]),
    .luma  (fg_luma)
  );

  ccc_merge u_merge (
    .clk     (clk),
    .en      (en),
    .bg_luma (bg_luma),
    .fg_luma (fg_luma),
    .ratio   (ratio_r),
    .passes  (passes),
    .bg_q16  (bg_q16),
    .fg_q16  (fg_q16)
  );

  assign out_tvalid = vld_r[ccc_pkg::PIPE_DEPTH-1];
  assign out_tdata  = {7'b0, fg_q16, bg_q16, passes};

endmodule

FILE: src/ccc_checker.sv
// Port-level checks for the color contrast checker, bound to the top level.
// Depends on color_contrast_checker_core.
`timescale 1ns / 1ps

module ccc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [39:0] out_tdata,
  input logic        out_tvalid,
  input logic        out_tready
);

  // a waiting item stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output item dropped or changed while stalled");

  // pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // an empty output register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // with the receiver ready, an accepted item shows up at the output
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) ##1 out_tready ##1 out_tready ##1 out_tready
      ##1 out_tready |=> out_tvalid)
    else $error("accepted item did not arrive after five cycles");

  // padding bits stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[39:33] == 7'b0)
    else $error("output padding not zero");

endmodule

bind color_contrast_checker_core ccc_checker u_ccc_checker (.*);
